[src/pvd_pkg.sv]
package pvd_pkg;

   localparam int COUNT_BITS = 24;

   localparam int DIFF_W   = 36;
   localparam int TOTAL_W  = 37;
   localparam int SQUARE_W = 60;
   localparam int PRES_W   = 13;
   localparam int DIST_W   = 53;

   localparam logic [1:0] METRIC_BRAY      = 2'd0;
   localparam logic [1:0] METRIC_EUCLID    = 2'd1;
   localparam logic [1:0] METRIC_MANHATTAN = 2'd2;
   localparam logic [1:0] METRIC_JACCARD   = 2'd3;

   localparam logic CSR_METRIC   = 1'b0;
   localparam logic CSR_WEIGHTED = 1'b1;

   typedef enum logic [2:0] {
      ST_ACCUM,
      ST_SETUP,
      ST_ITER,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } eng_ctrl_type;

endpackage

[src/pvd_engine.sv]
module pvd_engine #(
   parameter int OP_W  = 80,
   parameter int STEPS = 56
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pvd_pkg::eng_ctrl_type ctrl,
   input  logic [OP_W-1:0]      num,
   input  logic [OP_W-1:0]      den,
   output logic                 done,
   output logic [OP_W-1:0]      result
);

   localparam int CNT_W = $clog2(STEPS + 1);
   localparam int RW    = OP_W + 2;

   logic [OP_W-1:0]  num_ff, num_in;
   logic [OP_W-1:0]  den_ff, den_in;
   logic [OP_W-1:0]  q_ff, q_in;
   logic [RW-1:0]    rem_ff, rem_in;
   logic             sqrt_ff, sqrt_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [RW-1:0]    shifted, trial;

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      sqrt_in = sqrt_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = '0;
      trial   = '0;
      if (ctrl.start) begin
         num_in  = num;
         den_in  = den;
         q_in    = '0;
         rem_in  = '0;
         sqrt_in = ctrl.is_sqrt;
         cnt_in  = ctrl.is_sqrt ? CNT_W'(OP_W / 2) : CNT_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sqrt_ff) begin
            shifted = {rem_ff[RW-3:0], num_ff[OP_W-1 -: 2]};
            trial   = {2'b00, q_ff[OP_W-3:0], 2'b01};
            num_in  = {num_ff[OP_W-3:0], 2'b00};
         end else begin
            shifted = {rem_ff[RW-2:0], num_ff[OP_W-1]};
            trial   = {2'b00, den_ff};
            num_in  = {num_ff[OP_W-2:0], 1'b0};
         end
         if (shifted >= trial) begin
            rem_in = shifted - trial;
            q_in   = {q_ff[OP_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            q_in   = {q_ff[OP_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff  <= num_in;
      den_ff  <= den_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
      sqrt_ff <= sqrt_in;
   end

   assign done   = busy_ff && (cnt_ff == CNT_W'(1));
   assign result = q_in;

`ifndef SYNTHESIS
   a_cnt_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (cnt_ff != '0)) else $error("engine busy with zero count");
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done |=> !busy_ff || $past(ctrl.start)) else $error("engine busy after done");
   a_idle_cnt: assert property (@(posedge clock) disable iff (reset)
      (!busy_ff && !ctrl.start) |=> !busy_ff) else $error("engine started itself");
`endif

endmodule

[src/pairwise_vector_distance.sv]
// Pairwise distance between two abundance vectors.
// The request channel carries one element pair per transaction (req_x_count,
// req_y_count, req_last_element) with req_valid and req_stall. A pair that is
// not the last is accumulated in the cycle it is taken, so such pairs flow at
// one per cycle. The last pair closes the vector: the block then stalls the
// request channel while one shared shift-subtract unit iterates, one quotient
// or root bit per cycle, and then presents the distance on the response
// channel (rsp_valid, rsp_stall). From the edge that takes the last pair,
// the block passes through its setup state, its iterate state until the
// unit is done, and its result state, which drives rsp_valid. Manhattan
// also runs through the same unit as a divide by one. While the receiver
// stalls, the response is held and no new pair is accepted; the next pair
// can be taken in the cycle after the response is taken. Metric and weighted
// are set through the csr_ port; the user must write them only while the
// block is idle, as the block itself does not enforce this. Synchronous
// reset clears the accumulators, sets Bray-Curtis weighted, drops rsp_valid.
module pairwise_vector_distance #(
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_x_count,
   input  logic [23:0] req_y_count,
   input  logic        req_last_element,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [52:0] rsp_distance,
   output logic        rsp_undefined,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [1:0]  csr_data
);

   localparam int OP_W  = 64 + 2 * FRAC_BITS;
   localparam int STEPS = OP_W / 2 + 8;
   localparam int DW    = pvd_pkg::DIFF_W;
   localparam int TW    = pvd_pkg::TOTAL_W;
   localparam int SW    = pvd_pkg::SQUARE_W;
   localparam int PW    = pvd_pkg::PRES_W;
   localparam int OW    = pvd_pkg::DIST_W;

   pvd_pkg::state_type state_ff, state_in;
   logic [1:0]    metric_ff;
   logic          weighted_ff;
   logic [DW-1:0] diff_ff, diff_in;
   logic [TW-1:0] total_ff, total_in;
   logic [SW-1:0] square_ff, square_in;
   logic [PW-1:0] xp_ff, xp_in, yp_ff, yp_in, bp_ff, bp_in;
   logic [OW-1:0] dist_ff, dist_in;
   logic          undef_ff, undef_in;
   logic [OP_W-1:0] num_sel, den_sel;

   logic [23:0] mask, x, y, ad;
   logic [47:0] sq;
   logic        accept, eng_done;
   logic [OP_W-1:0] eng_result;
   pvd_pkg::eng_ctrl_type ctrl;
   logic [TW-1:0] t_sel;
   logic [TW:0]   d_sel, tpd;
   logic [SW-1:0] s_sel;
   logic [PW:0]   tu, bu2;

   assign mask = 24'((64'd1 << pvd_pkg::COUNT_BITS) - 64'd1);
   assign x  = req_x_count & mask;
   assign y  = req_y_count & mask;
   assign ad = (x > y) ? x - y : y - x;
   assign sq = ad * ad;
   assign accept = req_valid && !req_stall;
   assign req_stall = (state_ff != pvd_pkg::ST_ACCUM);

   always_comb begin
      logic [DW:0] ds;
      logic [TW:0] ts;
      logic [SW:0] ss;
      ds = {1'b0, diff_ff} + {(DW-23)'(0), ad};
      ts = {1'b0, total_ff} + (TW+1)'(x) + (TW+1)'(y);
      ss = {1'b0, square_ff} + (SW+1)'(sq);
      diff_in   = ds[DW] ? '1 : ds[DW-1:0];
      total_in  = ts[TW] ? '1 : ts[TW-1:0];
      square_in = ss[SW] ? '1 : ss[SW-1:0];
      xp_in = (x != 0 && xp_ff != '1) ? xp_ff + 1'b1 : xp_ff;
      yp_in = (y != 0 && yp_ff != '1) ? yp_ff + 1'b1 : yp_ff;
      bp_in = (x != 0 && y != 0 && bp_ff != '1) ? bp_ff + 1'b1 : bp_ff;
   end

   always_comb begin
      tu    = {1'b0, xp_ff} + {1'b0, yp_ff};
      bu2   = {bp_ff, 1'b0};
      if (weighted_ff) begin
         t_sel = total_ff;
         d_sel = (TW+1)'(diff_ff);
         s_sel = square_ff;
      end else begin
         t_sel = TW'(tu);
         d_sel = (bu2 <= tu) ? (TW+1)'(tu - bu2) : '0;
         s_sel = SW'(d_sel);
      end
      tpd = {1'b0, t_sel} + d_sel;
   end

   always_comb begin
      num_sel  = '0;
      den_sel  = '0;
      undef_in = undef_ff;
      unique case (metric_ff)
         pvd_pkg::METRIC_BRAY: begin
            num_sel = OP_W'(d_sel) << FRAC_BITS;
            den_sel = OP_W'(t_sel);
            undef_in = (t_sel == '0);
         end
         pvd_pkg::METRIC_EUCLID: begin
            num_sel = OP_W'(s_sel) << (2 * FRAC_BITS);
            den_sel = '0;
            undef_in = 1'b0;
         end
         pvd_pkg::METRIC_MANHATTAN: begin
            num_sel = OP_W'(d_sel) << FRAC_BITS;
            den_sel = OP_W'(1);
            undef_in = 1'b0;
         end
         default: begin
            num_sel = OP_W'(d_sel) << (FRAC_BITS + 1);
            den_sel = OP_W'(tpd);
            undef_in = (t_sel == '0);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pvd_pkg::ST_ACCUM:  if (accept && req_last_element) state_in = pvd_pkg::ST_SETUP;
         pvd_pkg::ST_SETUP:  state_in = pvd_pkg::ST_ITER;
         pvd_pkg::ST_ITER:   if (eng_done) state_in = pvd_pkg::ST_RESULT;
         pvd_pkg::ST_RESULT: if (!rsp_stall) state_in = pvd_pkg::ST_ACCUM;
         default:            state_in = pvd_pkg::ST_ACCUM;
      endcase
   end

   always_comb begin
      ctrl.start   = (state_ff == pvd_pkg::ST_SETUP);
      ctrl.is_sqrt = (metric_ff == pvd_pkg::METRIC_EUCLID);
      rsp_valid    = (state_ff == pvd_pkg::ST_RESULT);
   end

   always_comb begin
      dist_in = dist_ff;
      if (eng_done) begin
         if (undef_ff) dist_in = '0;
         else if (eng_result > OP_W'({OW{1'b1}})) dist_in = '1;
         else dist_in = OW'(eng_result);
      end
   end

   pvd_engine #(.OP_W(OP_W), .STEPS(STEPS)) u_engine (
      .clock (clock), .reset (reset), .ctrl (ctrl),
      .num ((metric_ff == pvd_pkg::METRIC_EUCLID) ? num_sel : num_sel << (OP_W - STEPS)),
      .den (den_sel), .done (eng_done), .result (eng_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= pvd_pkg::ST_ACCUM;
         metric_ff   <= pvd_pkg::METRIC_BRAY;
         weighted_ff <= 1'b1;
         diff_ff <= '0; total_ff <= '0; square_ff <= '0;
         xp_ff <= '0; yp_ff <= '0; bp_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            if (csr_index == pvd_pkg::CSR_METRIC) metric_ff <= csr_data;
            else weighted_ff <= csr_data[0];
         end
         if (accept) begin
            diff_ff <= diff_in; total_ff <= total_in; square_ff <= square_in;
            xp_ff <= xp_in; yp_ff <= yp_in; bp_ff <= bp_in;
         end else if (state_ff == pvd_pkg::ST_SETUP) begin
            diff_ff <= '0; total_ff <= '0; square_ff <= '0;
            xp_ff <= '0; yp_ff <= '0; bp_ff <= '0;
         end
      end
      if (state_ff == pvd_pkg::ST_SETUP) begin
         undef_ff <= undef_in;
      end
      dist_ff <= dist_in;
   end

   assign rsp_distance  = dist_ff;
   assign rsp_undefined = undef_ff;

`ifndef SYNTHESIS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_distance))
      else $error("response dropped under stall");
   a_undef: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_undefined) |-> (rsp_distance == '0))
      else $error("undefined distance not zero");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("request taken while result pending");
`endif

endmodule

[bench/tb_pairwise_vector_distance.sv]
module tb_pairwise_vector_distance;

   localparam int DIFF_W   = pvd_pkg::DIFF_W;
   localparam int TOTAL_W  = pvd_pkg::TOTAL_W;
   localparam int SQUARE_W = pvd_pkg::SQUARE_W;
   localparam int PRES_W   = pvd_pkg::PRES_W;
   localparam int DIST_W   = pvd_pkg::DIST_W;

   localparam logic [DIST_W-1:0] DIST_TOP = {DIST_W{1'b1}};
   localparam logic [23:0]       COUNT_TOP = 24'hFFFFFF;

   class distance_scoreboard;
      logic [1:0]          metric = pvd_pkg::METRIC_BRAY;
      logic                weighted = 1'b1;
      logic [DIFF_W-1:0]   diff_sum = '0;
      logic [TOTAL_W-1:0]  total_sum = '0;
      logic [SQUARE_W-1:0] square_sum = '0;
      logic [PRES_W-1:0]   x_present = '0;
      logic [PRES_W-1:0]   y_present = '0;
      logic [PRES_W-1:0]   both_present = '0;
      logic [DIST_W-1:0]   expected_distance[$];
      logic                expected_undefined[$];
      int                  mismatches = 0;

      function automatic logic [63:0] clamp_add(logic [63:0] a, logic [63:0] b,
                                                 logic [63:0] top);
         logic [63:0] sum;
         sum = a + b;
         return (sum > top) ? top : sum;
      endfunction

      function automatic logic [63:0] scaled_root(logic [63:0] s);
         logic [127:0] operand;
         logic [127:0] rem;
         logic [127:0] trial;
         logic [63:0]  root;
         operand = {64'd0, s} << (2 * 16);
         rem = '0;
         root = '0;
         for (int k = 63; k >= 0; k--) begin
            rem = (rem << 2) | ((operand >> (2 * k)) & 128'd3);
            trial = ({64'd0, root} << 2) | 128'd1;
            if (rem >= trial) begin
               rem = rem - trial;
               root = (root << 1) | 64'd1;
            end else begin
               root = root << 1;
            end
         end
         return root;
      endfunction

      function void note(logic [23:0] x, logic [23:0] y, logic last);
         logic [63:0] ad;
         logic [63:0] d;
         logic [63:0] t;
         logic [63:0] s;
         logic [63:0] dist_value;
         logic        undef;
         ad = (x > y) ? x - y : y - x;
         diff_sum   = DIFF_W'(clamp_add(64'(diff_sum), ad, 64'({DIFF_W{1'b1}})));
         total_sum  = TOTAL_W'(clamp_add(64'(total_sum), 64'(x) + 64'(y),
                                         64'({TOTAL_W{1'b1}})));
         square_sum = SQUARE_W'(clamp_add(64'(square_sum), ad * ad,
                                          64'({SQUARE_W{1'b1}})));
         if (x != 0)
            x_present = PRES_W'(clamp_add(64'(x_present), 64'd1, 64'({PRES_W{1'b1}})));
         if (y != 0)
            y_present = PRES_W'(clamp_add(64'(y_present), 64'd1, 64'({PRES_W{1'b1}})));
         if (x != 0 && y != 0)
            both_present = PRES_W'(clamp_add(64'(both_present), 64'd1,
                                             64'({PRES_W{1'b1}})));
         if (!last) return;
         if (weighted) begin
            d = 64'(diff_sum);
            t = 64'(total_sum);
            s = 64'(square_sum);
         end else begin
            t = 64'(x_present) + 64'(y_present);
            d = (64'd2 * 64'(both_present) <= t) ? t - 64'd2 * 64'(both_present) : 64'd0;
            s = d;
         end
         dist_value = 64'd0;
         undef = 1'b0;
         case (metric)
            pvd_pkg::METRIC_BRAY: begin
               if (t == 0) undef = 1'b1;
               else dist_value = (d << 16) / t;
            end
            pvd_pkg::METRIC_EUCLID: begin
               dist_value = scaled_root(s);
            end
            pvd_pkg::METRIC_MANHATTAN: begin
               dist_value = (d > (64'(DIST_TOP) >> 16)) ? 64'(DIST_TOP) : (d << 16);
            end
            default: begin
               if (t == 0) undef = 1'b1;
               else dist_value = ((64'd2 * d) << 16) / (t + d);
            end
         endcase
         if (dist_value > 64'(DIST_TOP)) dist_value = 64'(DIST_TOP);
         diff_sum = '0;
         total_sum = '0;
         square_sum = '0;
         x_present = '0;
         y_present = '0;
         both_present = '0;
         expected_distance.push_back(dist_value[DIST_W-1:0]);
         expected_undefined.push_back(undef);
      endfunction

      function void check(logic [DIST_W-1:0] got_distance, logic undef);
         logic [DIST_W-1:0] want_dist;
         logic              want_undef;
         if (expected_distance.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: distance %0d undefined %0b",
                        got_distance, undef);
            return;
         end
         want_dist = expected_distance.pop_front();
         want_undef = expected_undefined.pop_front();
         if (got_distance !== want_dist || undef !== want_undef) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result mismatch: expected distance %0d undefined %0b, got %0d %0b",
                        want_dist, want_undef, got_distance, undef);
         end
      endfunction

      function int pending();
         return expected_distance.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [23:0] req_x_count;
   logic [23:0] req_y_count;
   logic        req_last_element;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [52:0] rsp_distance;
   logic        rsp_undefined;
   logic        csr_write;
   logic        csr_index;
   logic [1:0]  csr_data;
   logic        quiet;

   distance_scoreboard board = new();

   pairwise_vector_distance i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_x_count(req_x_count),
      .req_y_count(req_y_count),
      .req_last_element(req_last_element),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_distance(rsp_distance),
      .rsp_undefined(rsp_undefined),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_pairwise_vector_distance: FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note(req_x_count, req_y_count, req_last_element);
      if (!reset && rsp_valid && !rsp_stall)
         board.check(rsp_distance, rsp_undefined);
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 23);
   end

   task automatic configure(logic [1:0] metric, logic weighted);
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= pvd_pkg::CSR_METRIC;
      csr_data <= metric;
      @(posedge clock);
      csr_index <= pvd_pkg::CSR_WEIGHTED;
      csr_data <= {1'b0, weighted};
      @(posedge clock);
      csr_write <= 1'b0;
      board.metric = metric;
      board.weighted = weighted;
   endtask

   task automatic send(logic [23:0] x, logic [23:0] y, logic last);
      while (!quiet && ($urandom_range(0, 99) < 23)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_x_count <= x;
      req_y_count <= y;
      req_last_element <= last;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [23:0] pick_count();
      case ($urandom_range(0, 4))
         0: return 24'd0;
         1: return COUNT_TOP;
         2: return 24'($urandom_range(0, 255));
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic send_vector(int length);
      for (int i = 0; i < length; i++)
         send(pick_count(), pick_count(), i == length - 1);
      req_valid <= 1'b0;
   endtask

   initial begin
      int items;
      int length;
      reset = 1'b1;
      req_valid = 1'b0;
      req_x_count = '0;
      req_y_count = '0;
      req_last_element = 1'b0;
      csr_write = 1'b0;
      csr_index = pvd_pkg::CSR_METRIC;
      csr_data = '0;
      quiet = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(COUNT_TOP, 24'd0, 1'b1);
      send(24'd0, 24'd0, 1'b1);
      req_valid <= 1'b0;
      for (int m = 0; m < 4; m++) begin
         for (int w = 0; w < 2; w++) begin
            configure(m[1:0], w[0]);
            send(24'd0, 24'd0, 1'b1);
            send(COUNT_TOP, 24'd0, 1'b0);
            send(24'd5, COUNT_TOP, 1'b1);
            send(24'd7, 24'd7, 1'b1);
            req_valid <= 1'b0;
         end
      end

      items = 0;
      while (items < 1360) begin
         configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         quiet = (items > 500 && items < 800);
         for (int v = 0; v < 8; v++) begin
            length = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(1, 8);
            send_vector(length);
            items += length;
         end
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("tb_pairwise_vector_distance: PASS");
      end else begin
         $display("tb_pairwise_vector_distance: FAIL");
      end
      $finish;
   end
endmodule
